### design/mwl_pkg.sv
// shared constants and types for the shortest window length block
package mwl_pkg;

    // store depth and derived widths
    localparam int MAX_ITEMS = 65536;
    localparam int ADDR_W    = $clog2(MAX_ITEMS);
    localparam int POS_W     = $clog2(MAX_ITEMS + 2);
    localparam int SUM_W     = 32;
    localparam int SAMPLE_W  = 16;
    localparam int LEN_W     = 17;

    // one finished sequence handed from loader to search engine
    typedef struct packed {
        logic [POS_W-1:0] n;
        logic [SUM_W-1:0] total;
    } job_t;

    // search engine status seen by the loader
    typedef struct packed {
        logic searching;
    } back_stat_t;

endpackage

### design/min_window_length_sum_threshold.sv
// Loading: one sample loads per cycle while full is low; after the last one the result is
//   queued without a search when the total falls short, else after a binary search whose probe
//   of length L scans windows over n samples, one window per cycle from the two-read-port prefix store.
// Flow: the next sequence loads while a result waits; loading stalls while a
//   finished sequence waits for the search and during its probes and scans.
// Reset: counters, handoff, result queue and target_sum cleared; prefix store kept.
module min_window_length_sum_threshold (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [mwl_pkg::SAMPLE_W-1:0] sample,
    input  logic                         is_last,
    output logic                         empty,
    input  logic                         pop,
    output logic [mwl_pkg::LEN_W-1:0]    min_length,
    input  logic                         cfg_wr_en,
    input  logic [mwl_pkg::SUM_W-1:0]    cfg_wr_data
);
    import mwl_pkg::*;

    logic [SUM_W-1:0]  target_sum_reg;
    back_stat_t        bstat;
    job_t              job;
    logic              job_valid;
    logic              job_take;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [SUM_W-1:0]  wr_data;
    logic              res_push;
    logic [LEN_W-1:0]  res_len;
    logic              res_full;

    // threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_sum_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            target_sum_reg <= cfg_wr_data;
        end
    end

    // loader
    mwl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .sample    (sample),
        .is_last   (is_last),
        .full      (full),
        .bstat     (bstat),
        .job       (job),
        .job_valid (job_valid),
        .job_take  (job_take),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    // search engine
    mwl_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .target_sum (target_sum_reg),
        .job        (job),
        .job_valid  (job_valid),
        .job_take   (job_take),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .bstat      (bstat),
        .res_push   (res_push),
        .res_len    (res_len),
        .res_full   (res_full)
    );

    // result queue
    mwl_res_q u_res_q (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (res_push),
        .wr_len     (res_len),
        .q_full     (res_full),
        .pop        (pop),
        .empty      (empty),
        .min_length (min_length)
    );

endmodule

### design/mwl_res_q.sv
// two-entry result queue in front of the output ports
module mwl_res_q (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  logic [mwl_pkg::LEN_W-1:0] wr_len,
    output logic                     q_full,
    input  logic                     pop,
    output logic                     empty,
    output logic [mwl_pkg::LEN_W-1:0] min_length
);
    import mwl_pkg::*;

    logic [LEN_W-1:0] slot_reg [2];
    logic             wptr_reg;
    logic             wptr_next;
    logic             rptr_reg;
    logic             rptr_next;
    logic [1:0]       cnt_reg;
    logic [1:0]       cnt_next;
    logic             do_wr;
    logic             do_rd;

    assign q_full     = (cnt_reg == 2'd2);
    assign empty      = (cnt_reg == 2'd0);
    assign min_length = slot_reg[rptr_reg];
    assign do_wr      = wr_en && !q_full;
    assign do_rd      = pop && !empty;

    // pointer and fill count update
    always_comb
    begin
        wptr_next = do_wr ? !wptr_reg : wptr_reg;
        rptr_next = do_rd ? !rptr_reg : rptr_reg;
        cnt_next  = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // payload slots
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wptr_reg] <= wr_len;
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("result queue count out of range");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |=> !(cnt_reg == 2'd0))
        else $error("result queue lost an entry");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd1) |-> (wptr_reg != rptr_reg))
        else $error("result queue pointers disagree with count");

endmodule

### design/mwl_front.sv
// loader: accumulates prefix sums and hands finished sequences to the search
module mwl_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  logic [mwl_pkg::SAMPLE_W-1:0] sample,
    input  logic                        is_last,
    output logic                        full,
    input  mwl_pkg::back_stat_t         bstat,
    output mwl_pkg::job_t               job,
    output logic                        job_valid,
    input  logic                        job_take,
    output logic                        wr_en,
    output logic [mwl_pkg::ADDR_W-1:0]  wr_addr,
    output logic [mwl_pkg::SUM_W-1:0]   wr_data
);
    import mwl_pkg::*;

    logic [POS_W-1:0] count_reg;
    logic [POS_W-1:0] count_next;
    logic [SUM_W-1:0] total_reg;
    logic [SUM_W-1:0] total_next;
    logic             job_valid_reg;
    logic             job_valid_next;
    job_t             job_reg;
    job_t             job_next;
    logic             accept;
    logic             has_room;
    logic [SUM_W-1:0] sum_new;
    logic [POS_W-1:0] cnt_new;

    // stall while a sequence waits or a search is running
    assign full     = job_valid_reg || bstat.searching;
    assign accept   = push && !full;
    assign has_room = (count_reg < POS_W'(MAX_ITEMS));
    assign sum_new  = has_room ? (total_reg + SUM_W'(sample)) : total_reg;
    assign cnt_new  = has_room ? (count_reg + POS_W'(1)) : count_reg;

    // prefix store write port
    assign wr_en   = accept && has_room;
    assign wr_addr = count_reg[ADDR_W-1:0];
    assign wr_data = sum_new;

    assign job       = job_reg;
    assign job_valid = job_valid_reg;

    // counters and job handoff
    always_comb
    begin
        count_next     = count_reg;
        total_next     = total_reg;
        job_valid_next = job_valid_reg && !job_take;
        job_next       = job_reg;
        if (accept)
        begin
            if (is_last)
            begin
                count_next     = '0;
                total_next     = '0;
                job_valid_next = 1'b1;
                job_next.n     = cnt_new;
                job_next.total = sum_new;
            end
            else
            begin
                count_next = cnt_new;
                total_next = sum_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            total_reg     <= '0;
            job_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            total_reg     <= total_next;
            job_valid_reg <= job_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !bstat.searching)
        else $error("store written during a scan");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= POS_W'(MAX_ITEMS))
        else $error("element count beyond store depth");
    a_job_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid_reg |-> (job_reg.n != '0))
        else $error("empty sequence handed to search");

endmodule

### design/mwl_back.sv
// search engine: prefix store plus binary search over window length
module mwl_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [mwl_pkg::SUM_W-1:0]  target_sum,
    input  mwl_pkg::job_t              job,
    input  logic                       job_valid,
    output logic                       job_take,
    input  logic                       wr_en,
    input  logic [mwl_pkg::ADDR_W-1:0] wr_addr,
    input  logic [mwl_pkg::SUM_W-1:0]  wr_data,
    output mwl_pkg::back_stat_t        bstat,
    output logic                       res_push,
    output logic [mwl_pkg::LEN_W-1:0]  res_len,
    input  logic                       res_full
);
    import mwl_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PROBE = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [SUM_W-1:0] mem [MAX_ITEMS];
    logic [SUM_W-1:0] rd_a_reg;
    logic [SUM_W-1:0] rd_b_reg;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [POS_W-1:0] n_reg;
    logic [POS_W-1:0] n_next;
    logic [POS_W-1:0] low_reg;
    logic [POS_W-1:0] low_next;
    logic [POS_W-1:0] high_reg;
    logic [POS_W-1:0] high_next;
    logic [POS_W-1:0] mid_reg;
    logic [POS_W-1:0] mid_next;
    logic [POS_W-1:0] end_reg;
    logic [POS_W-1:0] end_next;
    logic [LEN_W-1:0] res_reg;
    logic [LEN_W-1:0] res_next;
    logic             s1_v_reg;
    logic             s1_v_next;
    logic             s1_zero_reg;
    logic             s1_zero_next;

    logic             issue;
    logic             hit;
    logic [SUM_W-1:0] lower_sum;
    logic [SUM_W-1:0] win_sum;
    logic [POS_W-1:0] addr_a;
    logic [POS_W-1:0] addr_b;

    assign bstat.searching = (state_reg == S_PROBE) || (state_reg == S_SCAN);
    assign job_take        = (state_reg == S_IDLE) && job_valid;
    assign res_push        = (state_reg == S_EMIT);
    assign res_len         = res_reg;

    // window read addresses: upper prefix and lower prefix
    assign addr_a = end_reg - POS_W'(1);
    assign addr_b = end_reg - mid_reg - POS_W'(1);

    // window sum check on registered store data
    assign lower_sum = s1_zero_reg ? '0 : rd_b_reg;
    assign win_sum   = rd_a_reg - lower_sum;
    assign hit       = s1_v_reg && (win_sum >= target_sum);
    assign issue     = (state_reg == S_SCAN) && (end_reg <= n_reg) && !hit;

    // prefix store, one write and two reads per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem[addr_a[ADDR_W-1:0]];
        rd_b_reg <= mem[addr_b[ADDR_W-1:0]];
    end

    // search sequencer
    always_comb
    begin
        state_next   = state_reg;
        n_next       = n_reg;
        low_next     = low_reg;
        high_next    = high_reg;
        mid_next     = mid_reg;
        end_next     = end_reg;
        res_next     = res_reg;
        s1_v_next    = issue;
        s1_zero_next = (end_reg == mid_reg);
        unique case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    n_next    = job.n;
                    low_next  = POS_W'(1);
                    high_next = job.n;
                    if (job.total < target_sum)
                    begin
                        res_next   = '0;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_PROBE;
                    end
                end
            end
            S_PROBE:
            begin
                if (low_reg > high_reg)
                begin
                    res_next   = LEN_W'(low_reg);
                    state_next = S_EMIT;
                end
                else
                begin
                    mid_next   = low_reg + ((high_reg - low_reg) >> 1);
                    end_next   = low_reg + ((high_reg - low_reg) >> 1);
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (issue)
                begin
                    end_next = end_reg + POS_W'(1);
                end
                if (hit)
                begin
                    high_next  = mid_reg - POS_W'(1);
                    state_next = S_PROBE;
                end
                else if (!issue && !s1_v_reg)
                begin
                    low_next   = mid_reg + POS_W'(1);
                    state_next = S_PROBE;
                end
            end
            S_EMIT:
            begin
                if (!res_full)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            s1_v_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            s1_v_reg  <= s1_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        low_reg     <= low_next;
        high_reg    <= high_next;
        mid_reg     <= mid_next;
        end_reg     <= end_next;
        res_reg     <= res_next;
        s1_zero_reg <= s1_zero_next;
    end

    a_read_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        s1_v_reg |-> $past(state_reg == S_SCAN))
        else $error("store data checked outside a scan");
    a_mid_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (mid_reg >= low_reg && mid_reg <= high_reg))
        else $error("probe length outside search interval");
    a_result_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (POS_W'(res_reg) <= n_reg))
        else $error("result longer than sequence");
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        job_take |=> !(state_reg == S_SCAN))
        else $error("job taken while not idle");

endmodule

### tb/mwl_len_checker.sv
`timescale 1ns / 1ps
// checker for the shortest window length block: tracks prefix sums and compares results
module mwl_len_checker
    import mwl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic                full,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic                is_last,
    input  logic                empty,
    input  logic                pop,
    input  logic [LEN_W-1:0]    min_length,
    input  logic                cfg_wr_en,
    input  logic [SUM_W-1:0]    cfg_wr_data,
    output int                  fail_count,
    output int                  pending
);

    // entry k holds the sum of the first k samples, entry 0 stays zero
    logic [SUM_W-1:0] prefix_tbl [0:MAX_ITEMS];
    logic [SUM_W-1:0] run_sum    = '0;
    logic [SUM_W-1:0] target_reg = '0;
    int unsigned      fill       = 0;
    int               err_total  = 0;
    logic [LEN_W-1:0] len_q [$];
    logic [LEN_W-1:0] want_len;

    initial begin
        prefix_tbl[0] = '0;
        fail_count    = 0;
        pending       = 0;
    end

    // true when some window of the given length reaches the target
    function automatic logic window_fits(input int unsigned len, input int unsigned n);
        int unsigned      e;
        logic [SUM_W-1:0] w;
        for (e = len; e <= n; e++) begin
            w = prefix_tbl[e] - prefix_tbl[e - len];
            if (w >= target_reg)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // binary search over window length, 0 when the whole sequence falls short
    function automatic logic [LEN_W-1:0] shortest_window(input int unsigned n);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        if (run_sum < target_reg)
            return '0;
        lo = 1;
        hi = n;
        while (lo <= hi) begin
            mid = lo + ((hi - lo) >> 1);
            if (window_fits(mid, n))
                hi = mid - 1;
            else
                lo = mid + 1;
        end
        return lo[LEN_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            fill       = 0;
            run_sum    = '0;
            target_reg = '0;
            len_q.delete();
        end
        else begin
            // register write
            if (cfg_wr_en)
                target_reg = cfg_wr_data;

            // input transaction: store the sample unless the store is full
            if (push && !full) begin
                if (fill < MAX_ITEMS) begin
                    run_sum = run_sum + sample;
                    fill++;
                    prefix_tbl[fill] = run_sum;
                end
                if (is_last) begin
                    len_q.push_back(shortest_window(fill));
                    fill    = 0;
                    run_sum = '0;
                end
            end

            // result transaction
            if (pop && !empty) begin
                if (len_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual min_length %0d",
                             $time, min_length);
                    err_total++;
                end
                else begin
                    want_len = len_q.pop_front();
                    if (min_length !== want_len) begin
                        $display("%0t: min_length mismatch, expected %0d, actual %0d",
                                 $time, want_len, min_length);
                        err_total++;
                    end
                end
            end
        end
        fail_count <= err_total;
        pending    <= len_q.size();
    end

endmodule

### tb/tb_min_window_length_sum_threshold.sv
`timescale 1ns / 1ps
// testbench top: stimulus, idle phases and verdict for the shortest window length block
module tb_min_window_length_sum_threshold;
    import mwl_pkg::*;

    localparam int CYCLE_LIMIT   = 4_000_000;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_ITEMS   = 36;
    localparam int PHASE_COUNT   = 12;
    localparam int HOLD_CYCLES   = 600;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                push        = 1'b0;
    logic [SAMPLE_W-1:0] sample      = '0;
    logic                is_last     = 1'b0;
    logic                pop         = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [SUM_W-1:0]    cfg_wr_data = '0;
    logic                full;
    logic                empty;
    logic [LEN_W-1:0]    min_length;

    int fail_count;
    int pending;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int cycle_count    = 0;

    logic [SAMPLE_W-1:0] seq_buf [$];

    min_window_length_sum_threshold uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .sample      (sample),
        .is_last     (is_last),
        .empty       (empty),
        .pop         (pop),
        .min_length  (min_length),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    mwl_len_checker len_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .sample      (sample),
        .is_last     (is_last),
        .empty       (empty),
        .pop         (pop),
        .min_length  (min_length),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_min_window_length_sum_threshold failed");
        $finish;
    end

    // result side: random stalls plus an optional long hold-off
    initial begin
        wait (rst_n);
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                pop <= 1'b0;
                hold_left--;
            end
            else begin
                pop <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // offer one sample, idling first at the current rate, and wait for the transaction
    task automatic send_item(input logic [SAMPLE_W-1:0] val, input logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            push    <= 1'b0;
            sample  <= SAMPLE_W'($urandom_range(16'hFFFF));
            is_last <= 1'($urandom_range(1));
            @(posedge clk);
        end
        push    <= 1'b1;
        sample  <= val;
        is_last <= fin;
        do @(posedge clk); while (full);
    endtask

    task automatic send_buf();
        foreach (seq_buf[i])
            send_item(seq_buf[i], i == seq_buf.size() - 1);
    endtask

    // wait until every expected result has come back, then let the block settle
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_target(input logic [SUM_W-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= val;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        @(posedge clk);
    endtask

    // sample biased toward zero and the phase maximum
    function automatic logic [SAMPLE_W-1:0] pick_sample(input int unsigned cap);
        case ($urandom_range(9))
            0:       return '0;
            1:       return SAMPLE_W'(cap);
            default: return SAMPLE_W'($urandom_range(cap));
        endcase
    endfunction

    initial begin
        int          p;
        int          k;
        int          len;
        int          sent;
        int unsigned cap;
        logic [SUM_W-1:0] tgt;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // target at its reset value of zero: any window qualifies
        seq_buf = '{16'hFFFF};
        send_buf();
        seq_buf = '{16'd0, 16'd0, 16'd0};
        send_buf();
        drain();

        // largest target, sequence falls short
        write_target('1);
        seq_buf = '{16'hFFFF, 16'hFFFF, 16'd0};
        send_buf();
        drain();

        // two maximum samples make the only qualifying pair
        write_target(32'd131070);
        seq_buf = '{16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF};
        send_buf();
        drain();

        // whole sequence needed, single element, window spanning zeros
        write_target(32'd5);
        seq_buf = '{16'd1, 16'd1, 16'd1, 16'd1, 16'd1};
        send_buf();
        seq_buf = '{16'd0, 16'd0, 16'd7};
        send_buf();
        seq_buf = '{16'd2, 16'd0, 16'd0, 16'd3};
        send_buf();
        drain();

        // random phases cycling through the idle modes
        for (p = 0; p < PHASE_COUNT; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            case ($urandom_range(3))
                0:       cap = 15;
                1:       cap = 255;
                2:       cap = 4095;
                default: cap = 65535;
            endcase
            if (p == 1)
                tgt = '0;
            else if (p == 2)
                tgt = '1;
            else if ($urandom_range(4) == 0)
                tgt = $urandom;
            else
                tgt = $urandom_range(cap * 12, 1);
            write_target(tgt);

            // first phase: hold results off so the block backs up into full
            if (p == 0)
                hold_left = HOLD_CYCLES;

            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if (p == 0)
                    len = $urandom_range(3, 1);
                else if ($urandom_range(9) == 0)
                    len = $urandom_range(150, 17);
                else
                    len = $urandom_range(16, 1);
                for (k = 0; k < len; k++)
                    send_item(pick_sample(cap), k == len - 1);
                sent += len;
            end
            drain();
        end

        if (fail_count == 0 && pending == 0)
            $display("tb_min_window_length_sum_threshold passed");
        else
            $display("tb_min_window_length_sum_threshold failed");
        $finish;
    end

endmodule

### filelist.f
design/mwl_pkg.sv
design/mwl_res_q.sv
design/mwl_front.sv
design/mwl_back.sv
design/min_window_length_sum_threshold.sv
tb/mwl_len_checker.sv
tb/tb_min_window_length_sum_threshold.sv
